FILE: hdl/bcc_pkg.sv
`default_nettype none
package bcc_pkg;

  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W       = CNT_W + 1;

  localparam int unsigned TIME_W      = 32;
  localparam int unsigned DEBOUNCE_W  = 16;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd30;
  localparam logic [TIME_W-1:0]     DOUBLE_RST   = 32'd300;
  localparam logic [TIME_W-1:0]     LONG_RST     = 32'd500;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_POP    = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PRESSED = 3'd1,
    EV_SHORT   = 3'd2,
    EV_LONG    = 3'd3,
    EV_DOUBLE  = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_DOUBLE   = 2'd1,
    CFG_LONG     = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_WAIT   = 3'b010,
    MODE_FORGET = 3'b100
  } mode_t;

  // Decoded request handed from the front to the back.
  typedef struct packed {
    logic              sample;
    logic              pop;
    logic              flush;
    logic              level;
    logic [TIME_W-1:0] now_ms;
  } req_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [TIME_W-1:0]    wdata;
  } cfg_t;

endpackage
`default_nettype wire

FILE: hdl/button_click_classifier_fifo.sv
`default_nettype none
// Channel   Handshake              Payload
// in        in_valid / in_stall    in_op[1:0], in_pin_level, in_now_ms[31:0]
// out       out_valid / out_stall  out_event_code[2:0], out_event_dropped, out_queue_count[3:0]
// cfg       cfg_we                 cfg_index[1:0], cfg_wdata[31:0]
//
// One request per cycle while out_stall does not hold the result register; an accepted
// request is written into the two-entry queue, then classified, and the event ring and
// result register are updated when the back takes it from the queue.
// rst_n is synchronous; it restores register defaults, click state and an empty queue.
// in_stall rises only when the request queue is full, i.e. after out_stall has held.
// out_stall holds the result register; the front keeps taking requests until the queue fills.
module button_click_classifier_fifo (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic        in_pin_level,
  input  wire logic [31:0] in_now_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_event_code,
  output logic             out_event_dropped,
  output logic [3:0]       out_queue_count,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  bcc_pkg::req_t req;
  bcc_pkg::cfg_t cfg;
  logic          req_valid;
  logic          req_take;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.wdata = cfg_wdata;

  bcc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_pin_level (in_pin_level),
    .in_now_ms    (in_now_ms),
    .req_valid    (req_valid),
    .req          (req),
    .req_take     (req_take)
  );

  bcc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .req_valid         (req_valid),
    .req               (req),
    .req_take          (req_take),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_code    (out_event_code),
    .out_event_dropped (out_event_dropped),
    .out_queue_count   (out_queue_count)
  );

endmodule
`default_nettype wire

FILE: hdl/bcc_front.sv
`default_nettype none
module bcc_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   in_op,
  input  wire logic                         in_pin_level,
  input  wire logic [bcc_pkg::TIME_W-1:0]   in_now_ms,
  output logic                              req_valid,
  output bcc_pkg::req_t                     req,
  input  wire logic                         req_take
);

  bcc_pkg::req_t entry_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r,  count_nxt;
  bcc_pkg::req_t dec;
  logic          push, pop;

  // Decode op into one-hot request kind; unused op becomes a no-op.
  always_comb begin
    dec        = '0;
    dec.level  = in_pin_level;
    dec.now_ms = in_now_ms;
    unique case (bcc_pkg::op_t'(in_op))
      bcc_pkg::OP_SAMPLE: dec.sample = 1'b1;
      bcc_pkg::OP_POP:    dec.pop    = 1'b1;
      bcc_pkg::OP_FLUSH:  dec.flush  = 1'b1;
      default:            dec.sample = 1'b0;
    endcase
  end

  assign in_stall  = (count_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign req_valid = (count_r != 2'd0);
  assign req       = entry_r[rd_ptr_r];
  assign pop       = req_valid && req_take;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= dec;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/bcc_back.sv
`default_nettype none
module bcc_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bcc_pkg::cfg_t                cfg,
  input  wire logic                         req_valid,
  input  wire bcc_pkg::req_t                req,
  output logic                              req_take,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [2:0]                        out_event_code,
  output logic                              out_event_dropped,
  output logic [3:0]                        out_queue_count
);

  localparam int unsigned PTR_W = bcc_pkg::PTR_W;
  localparam int unsigned CNT_W = bcc_pkg::CNT_W;
  localparam int unsigned SUM_W = bcc_pkg::SUM_W;
  localparam int unsigned TW    = bcc_pkg::TIME_W;

  logic [bcc_pkg::DEBOUNCE_W-1:0] debounce_r;
  logic [TW-1:0]                  double_r;
  logic [TW-1:0]                  long_r;

  logic [TW-1:0]     change_time_r, change_time_nxt;
  logic              last_level_r,  last_level_nxt;
  bcc_pkg::mode_t    mode_r,        mode_nxt;
  logic [2:0]        ring_r [bcc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  head_r,        head_nxt;
  logic [CNT_W-1:0]  count_r,       count_nxt;

  logic              out_valid_r;
  logic [2:0]        code_r,        code_nxt;
  logic              dropped_r,     dropped_nxt;
  logic [CNT_W-1:0]  qcount_r;

  logic [TW-1:0]     elapsed;
  bcc_pkg::event_t   cls_code;
  bcc_pkg::mode_t    cls_mode;
  logic              cls_last;
  logic [TW-1:0]     cls_change;
  logic              fire, has_room, has_event, push;
  logic [SUM_W-1:0]  slot_sum;
  logic [PTR_W-1:0]  slot;
  logic [CNT_W+3:0]  qcount_ext;

  assign fire     = req_valid && (!out_valid_r || !out_stall);
  assign req_take = fire;

  // Classify one sample against the held level and click mode.
  always_comb begin
    elapsed    = req.now_ms - change_time_r;
    cls_code   = bcc_pkg::EV_NONE;
    cls_mode   = mode_r;
    cls_last   = last_level_r;
    cls_change = change_time_r;
    if (elapsed >= {{(TW-bcc_pkg::DEBOUNCE_W){1'b0}}, debounce_r}) begin
      if (req.level == last_level_r) begin
        if (!req.level) begin
          if (mode_r == bcc_pkg::MODE_IDLE && elapsed > long_r) begin
            cls_mode = bcc_pkg::MODE_FORGET;
            cls_code = bcc_pkg::EV_LONG;
          end
        end else if (mode_r != bcc_pkg::MODE_IDLE && elapsed > double_r) begin
          cls_mode = bcc_pkg::MODE_IDLE;
          cls_code = bcc_pkg::EV_SHORT;
        end
      end else begin
        cls_last   = req.level;
        cls_change = req.now_ms;
        if (!req.level) begin
          if (mode_r == bcc_pkg::MODE_WAIT) begin
            cls_mode = bcc_pkg::MODE_FORGET;
            cls_code = bcc_pkg::EV_DOUBLE;
          end else begin
            cls_mode = bcc_pkg::MODE_IDLE;
            cls_code = bcc_pkg::EV_PRESSED;
          end
        end else begin
          cls_mode = (mode_r != bcc_pkg::MODE_IDLE) ? bcc_pkg::MODE_IDLE : bcc_pkg::MODE_WAIT;
        end
      end
    end
  end

  assign has_room  = (count_r < CNT_W'(bcc_pkg::QUEUE_DEPTH));
  assign has_event = (cls_code != bcc_pkg::EV_NONE);
  assign push      = fire && req.sample && has_event && has_room;

  // Tail slot wraps at most once since head is below the depth and count is at most the depth.
  always_comb begin
    slot_sum = SUM_W'(head_r) + SUM_W'(count_r);
    if (slot_sum >= SUM_W'(bcc_pkg::QUEUE_DEPTH)) begin
      slot_sum = slot_sum - SUM_W'(bcc_pkg::QUEUE_DEPTH);
    end
    slot = slot_sum[PTR_W-1:0];
  end

  always_comb begin
    change_time_nxt = change_time_r;
    last_level_nxt  = last_level_r;
    mode_nxt        = mode_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    code_nxt        = bcc_pkg::EV_NONE;
    dropped_nxt     = 1'b0;
    priority if (req.sample) begin
      change_time_nxt = cls_change;
      last_level_nxt  = cls_last;
      mode_nxt        = cls_mode;
      code_nxt        = cls_code;
      dropped_nxt     = has_event && !has_room;
      if (has_event && has_room) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (req.pop) begin
      if (count_r != '0) begin
        code_nxt  = ring_r[head_r];
        head_nxt  = (head_r == PTR_W'(bcc_pkg::QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
        count_nxt = count_r - CNT_W'(1);
      end
    end else if (req.flush) begin
      mode_nxt  = bcc_pkg::MODE_IDLE;
      head_nxt  = '0;
      count_nxt = '0;
    end else begin
      code_nxt = bcc_pkg::EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r    <= bcc_pkg::DEBOUNCE_RST;
      double_r      <= bcc_pkg::DOUBLE_RST;
      long_r        <= bcc_pkg::LONG_RST;
      change_time_r <= '0;
      last_level_r  <= 1'b1;
      mode_r        <= bcc_pkg::MODE_IDLE;
      head_r        <= '0;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg.we) begin
        if (cfg.index == bcc_pkg::CFG_DEBOUNCE) begin
          debounce_r <= cfg.wdata[bcc_pkg::DEBOUNCE_W-1:0];
        end
        if (cfg.index == bcc_pkg::CFG_DOUBLE) begin
          double_r <= cfg.wdata;
        end
        if (cfg.index == bcc_pkg::CFG_LONG) begin
          long_r <= cfg.wdata;
        end
      end
      if (fire) begin
        change_time_r <= change_time_nxt;
        last_level_r  <= last_level_nxt;
        mode_r        <= mode_nxt;
        head_r        <= head_nxt;
        count_r       <= count_nxt;
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: ring entries and result fields.
  always_ff @(posedge clk) begin
    if (push) begin
      ring_r[slot] <= cls_code;
    end
    if (fire) begin
      code_r    <= code_nxt;
      dropped_r <= dropped_nxt;
      qcount_r  <= count_nxt;
    end
  end

  assign qcount_ext        = {4'd0, qcount_r};
  assign out_valid         = out_valid_r;
  assign out_event_code    = code_r;
  assign out_event_dropped = dropped_r;
  assign out_queue_count   = qcount_ext[3:0];

endmodule
`default_nettype wire
